[design/sld_pkg.sv]
// Shared types and constants for the sinc low-pass decimator.
package sld_pkg;

    localparam int SMP_W = 16;
    localparam int TAP_W = 18;
    localparam int TAP_FRAC = 17;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAP_ONE = 64'd131072;
    localparam int SIN_TERMS = 9;
    // Taylor series divisors (2j)(2j+1) for j = 1..9
    localparam longint unsigned SIN_DEN [SIN_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    typedef struct packed {
        logic accept;
        logic issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

[design/sld_in_if.sv]
// Input sample channel: valid/ready handshake with sample payload.
interface sld_in_if import sld_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_in;
    logic                    start_of_signal;

    modport source (output valid, output sample_in, output start_of_signal, input ready);
    modport sink (input valid, input sample_in, input start_of_signal, output ready);
endinterface

[design/sld_out_if.sv]
// Output sample channel: valid/ready handshake with filtered sample payload.
interface sld_out_if import sld_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink (input valid, input filtered_sample, output ready);
endinterface

[design/sinc_lowpass_decimator.sv]
// Top level: sinc low-pass FIR with decimation, controller plus datapath.
//
// Usage: samples arrive on i_in (valid/ready, sample_in Q15, start_of_signal)
// and filtered samples leave on o_out (valid/ready, filtered_sample Q15).
// The filter is causal with 2*HALF_TAPS+1 taps, so the output lags the input
// by HALF_TAPS samples; history before the first sample of a signal is zero.
// The first sample of a signal and every DECIM-th one after it produce one
// result; the others produce none.
// Non-producing samples are taken back to back. A producing sample holds the
// input while the single multiply-accumulate sweeps the N valid history
// entries (N up to 2*HALF_TAPS+1) through the one read port of the delay
// line memory, drains the product and accumulate registers, and waits until
// the output register can take the result.
// Reset clears the counters and phase; the delay line is not cleared, the
// history count keeps unwritten entries out of the sum. No clearing pass.
// A stalled receiver keeps the result in the output register; sampling
// continues until the next result is ready, which then waits for the slot.
module sinc_lowpass_decimator import sld_pkg::*; #(
    parameter int HALF_TAPS = 1000,
    parameter int DECIM     = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sld_in_if.sink   i_in,
    sld_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    sld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sld_datapath #(
        .HALF_TAPS (HALF_TAPS),
        .DECIM     (DECIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_in.sample_in),
        .i_start     (i_in.start_of_signal),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.filtered_sample)
    );

    assign i_in.ready = w_in_ready;

endmodule

[design/sld_ctrl.sv]
// Controller state machine: input transfer, MAC sweep, drain and result load.
module sld_ctrl import sld_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = r_ready & i_in_valid;
        o_cmd.issue    = (r_state == S_ISSUE);
        o_cmd.load_out = (r_state == S_EMIT) & i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_status.emit) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (i_status.last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) n_state = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the result
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");
    a_emit_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.emit) |=> (r_state == S_ISSUE && !r_ready))
        else $error("emitting sample did not start the MAC sweep");
    a_plain_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_status.emit) |=> (r_state == S_IDLE && r_ready))
        else $error("non-emitting sample blocked the input");
`endif

endmodule

[design/sld_datapath.sv]
// Datapath: delay line memory, tap ROM, multiply-accumulate, rounding and output register.
module sld_datapath import sld_pkg::*; #(
    parameter int HALF_TAPS = 1000,
    parameter int DECIM     = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_start,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [SMP_W-1:0] o_out_data
);

    localparam int NTAPS  = 2 * HALF_TAPS + 1;
    localparam int IDX_W  = $clog2(NTAPS);
    localparam int CNT_W  = $clog2(NTAPS + 1);
    localparam int PH_W   = $clog2(DECIM);
    localparam int PROD_W = TAP_W + SMP_W;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int RND_W  = ACC_W + 1 - TAP_FRAC;

    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(32768);
    localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W+1)'(65536);

    typedef logic signed [TAP_W-1:0] t_taps [NTAPS];

    // Shift-subtract division used while building the tap table.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (int j = 0; j < SIN_TERMS; j++) begin
            term = ((term * x2) >> 30) / SIN_DEN[j];
            if (j % 2 == 0) neg = neg + term;
            else pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic logic signed [TAP_W-1:0] tap_value(int k);
        longint unsigned a;
        longint unsigned r;
        longint unsigned s;
        longint unsigned p;
        longint unsigned mag;
        logic            negative;
        negative = 1'b0;
        a = (k >= HALF_TAPS) ? longint'(k - HALF_TAPS) : longint'(HALF_TAPS - k);
        if (a == 0) return TAP_W'((TAP_ONE + DECIM / 2) / DECIM);
        r = a % (2 * DECIM);
        if (r >= DECIM) begin
            negative = 1'b1;
            r = r - DECIM;
        end
        if (2 * r > DECIM) r = DECIM - r;
        s   = sin_q30((PI_Q30 * r) / DECIM);
        p   = PI_Q30 * a;
        mag = udiv((s << TAP_FRAC) + p / 2, p);
        return negative ? -TAP_W'(mag) : TAP_W'(mag);
    endfunction

    function automatic t_taps build_taps();
        t_taps rom;
        for (int k = 0; k < NTAPS; k++) rom[k] = tap_value(k);
        return rom;
    endfunction

    localparam t_taps TAP_ROM = build_taps();

    logic        [SMP_W-1:0] r_hist_mem [NTAPS];
    logic        [IDX_W-1:0] r_head;
    logic        [IDX_W-1:0] n_head;
    logic        [CNT_W-1:0] r_seen;
    logic        [CNT_W-1:0] w_base_seen;
    logic        [PH_W-1:0]  r_phase;
    logic        [PH_W-1:0]  w_base_ph;
    logic        [IDX_W-1:0] r_k;
    logic        [IDX_W-1:0] r_rd_ptr;
    logic                    r_v1;
    logic                    r_v2;
    logic signed [SMP_W-1:0] r_hist_q;
    logic signed [TAP_W-1:0] r_tap_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W:0]   w_rnd;
    logic signed [RND_W-1:0] w_q;
    logic signed [SMP_W-1:0] n_result;
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_data;

    // A start mark drops the old history count and phase before the sample is taken.
    assign w_base_seen = i_start ? '0 : r_seen;
    assign w_base_ph   = i_start ? '0 : r_phase;
    assign n_head      = (r_head == IDX_W'(NTAPS - 1)) ? '0 : r_head + 1'b1;

    assign o_status.emit       = (w_base_ph == '0);
    assign o_status.last_issue = (CNT_W'(r_k) + CNT_W'(1)) == r_seen;
    assign o_status.pipe_busy  = r_v1 | r_v2;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Round half up at Q32 -> Q15, then saturate.
    assign w_rnd = (ACC_W+1)'(r_acc) + RND_HALF;
    assign w_q   = $signed(w_rnd[ACC_W:TAP_FRAC]);

    always_comb begin
        if (w_q > SAT_MAX) n_result = SMP_W'(SAT_MAX);
        else if (w_q < SAT_MIN) n_result = SMP_W'(SAT_MIN);
        else n_result = SMP_W'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_seen      <= '0;
            r_phase     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_head  <= n_head;
                r_seen  <= (w_base_seen < CNT_W'(NTAPS)) ? w_base_seen + 1'b1 : w_base_seen;
                r_phase <= (w_base_ph == PH_W'(DECIM - 1)) ? '0 : w_base_ph + 1'b1;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_hist_mem[n_head] <= i_sample;
        if (i_cmd.issue) begin
            r_hist_q <= r_hist_mem[r_rd_ptr];
            r_tap_q  <= TAP_ROM[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.emit) begin
            r_k      <= '0;
            r_rd_ptr <= n_head;
        end else if (i_cmd.issue) begin
            r_k      <= r_k + 1'b1;
            r_rd_ptr <= (r_rd_ptr == '0) ? IDX_W'(NTAPS - 1) : r_rd_ptr - 1'b1;
        end
        r_prod <= r_tap_q * r_hist_q;
        if (i_cmd.accept && o_status.emit) r_acc <= '0;
        else if (r_v2) r_acc <= r_acc + ACC_W'(r_prod);
        if (i_cmd.load_out) r_out_data <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> CNT_W'(r_k) < r_seen)
        else $error("tap index beyond valid history");
    a_accept_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (!r_v1 && !r_v2))
        else $error("sample transfer while MAC pipeline busy");
    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_seen != '0 && r_seen <= CNT_W'(NTAPS)))
        else $error("history count out of range");
`endif

endmodule

[test/sld_checker.sv]
// Scoreboard for the sinc low-pass decimator: predicts each filtered sample and checks the output.
module sld_checker import sld_pkg::*; #(
    parameter int HALF_TAPS = 1000,
    parameter int DECIM     = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sld_in_if    i_in_mon,
    sld_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS = 2 * HALF_TAPS + 1;
    localparam longint signed OUT_MAX = 32767;
    localparam longint signed OUT_MIN = -32768;

    longint signed           coeff_rom [NTAPS];
    logic signed [SMP_W-1:0] delay_line [NTAPS];
    int                      head_idx = 0;
    int                      hist_len = 0;
    int                      dec_phase = 0;
    logic signed [SMP_W-1:0] filtered_q [$];

    int fail_total = 0;
    int checked_total = 0;
    int clipped_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = filtered_q.size();
    assign o_checked    = checked_total;
    assign o_saturated  = clipped_total;

    // Q30 sine by truncated Taylor series, same term truncation as the tap ROM build
    function automatic longint unsigned sine_q30(longint unsigned x);
        longint unsigned x_sq, term, pos_sum, neg_sum, denom;
        int j;
        x_sq    = (x * x) >> 30;
        term    = x;
        pos_sum = x;
        neg_sum = 0;
        for (j = 1; j < 10; j++) begin
            denom = (2 * j) * (2 * j + 1);
            term  = ((term * x_sq) >> 30) / denom;
            if (j % 2 == 1) neg_sum += term;
            else            pos_sum += term;
        end
        return (pos_sum > neg_sum) ? pos_sum - neg_sum : 0;
    endfunction

    function automatic longint signed coeff_at(int k);
        longint unsigned lag, rem, sn, span, mag;
        logic neg;
        neg  = 1'b0;
        lag  = (k >= HALF_TAPS) ? k - HALF_TAPS : HALF_TAPS - k;
        if (lag == 0) return $signed((TAP_ONE + DECIM / 2) / DECIM);
        rem = lag % (2 * DECIM);
        if (rem >= DECIM) begin
            neg = 1'b1;
            rem -= DECIM;
        end
        if (2 * rem > DECIM) rem = DECIM - rem;
        sn   = sine_q30((PI_Q30 * rem) / DECIM);
        span = PI_Q30 * lag;
        mag  = ((sn << TAP_FRAC) + span / 2) / span;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    initial begin
        for (int k = 0; k < NTAPS; k++) coeff_rom[k] = coeff_at(k);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_total++;
    endtask

    // Advance the delay line by one sample; queue a result on decimation phase zero
    function automatic void advance_filter(logic signed [SMP_W-1:0] smp, logic first);
        longint signed acc;
        longint signed rounded;
        int idx;
        int k;
        logic produce;
        if (first) begin
            hist_len  = 0;
            dec_phase = 0;
        end
        head_idx = (head_idx + 1 >= NTAPS) ? 0 : head_idx + 1;
        delay_line[head_idx] = smp;
        if (hist_len < NTAPS) hist_len++;
        produce   = (dec_phase == 0);
        dec_phase = (dec_phase + 1 >= DECIM) ? 0 : dec_phase + 1;
        if (produce) begin
            acc = 0;
            for (k = 0; k < hist_len; k++) begin
                idx = (head_idx >= k) ? head_idx - k : head_idx + NTAPS - k;
                acc += coeff_rom[k] * longint'(delay_line[idx]);
            end
            // round half up out of Q32, then clip to 16 bits
            rounded = (acc + 65536) >>> TAP_FRAC;
            if (rounded > OUT_MAX) begin
                rounded = OUT_MAX;
                clipped_total++;
            end else if (rounded < OUT_MIN) begin
                rounded = OUT_MIN;
                clipped_total++;
            end
            filtered_q.push_back(SMP_W'(rounded));
        end
    endfunction

    always @(posedge i_clk) begin
        logic signed [SMP_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                advance_filter(i_in_mon.sample_in, i_in_mon.start_of_signal);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("filtered_sample %0d with no result pending",
                                              i_out_mon.filtered_sample));
                end else begin
                    want = filtered_q.pop_front();
                    if (i_out_mon.filtered_sample !== want)
                        report_mismatch($sformatf("filtered_sample #%0d: got %0d, want %0d",
                                                  checked_total, i_out_mon.filtered_sample,
                                                  want));
                    checked_total++;
                end
            end
        end
    end

endmodule

[test/tb.sv]
// Testbench top: clock, reset, sample stimulus and output back-pressure for the decimator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sld_pkg::*;

    localparam int HALF_TAPS      = 1000;
    localparam int DECIM          = 4;
    localparam int NTAPS          = 2 * HALF_TAPS + 1;
    localparam int LONG_ITEMS     = 600;
    localparam int RAND_ITEMS     = 500;
    localparam int CALM_ITEMS     = 120;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int DRAIN_LIMIT    = 20000;

    localparam logic signed [SMP_W-1:0] SMP_MAX  = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN  = 16'sh8000;
    localparam logic signed [SMP_W-1:0] SMP_ZERO = 16'sh0000;

    typedef enum int {WAVE_NOISE, WAVE_RAILS, WAVE_QUIET, WAVE_SQUARE, WAVE_LEVEL} t_wave;

    logic clk;
    logic rst_n;

    sld_in_if  in_ch ();
    sld_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int saturated;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req = 1'b0;
    int samples_sent = 0;
    int marks_sent = 0;
    int longest_run = 0;

    sinc_lowpass_decimator #(
        .HALF_TAPS(HALF_TAPS),
        .DECIM(DECIM)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    sld_checker #(
        .HALF_TAPS(HALF_TAPS),
        .DECIM(DECIM)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_mon(in_ch),
        .i_out_mon(out_ch),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked),
        .o_saturated(saturated)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #32_000_000;
        $display("sinc_lowpass_decimator regression: fail");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                stall_left  = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (stall_left == 0 && rx_stall_pct != 0 &&
                         $urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic first);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.sample_in       <= smp;
        in_ch.start_of_signal <= first;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        samples_sent++;
        if (first) marks_sent++;
    endtask

    // One signal: start mark on its first sample (when marked), rare stray marks inside
    task automatic send_signal(input int len, input t_wave wave, input logic marked);
        logic signed [SMP_W-1:0] smp;
        logic signed [SMP_W-1:0] level;
        int half_period;
        int n;
        logic first;
        half_period = $urandom_range(8, 300);
        level = $urandom_range(0, 1) ? SMP_MAX : SMP_W'($urandom);
        for (n = 0; n < len; n++) begin
            case (wave)
                WAVE_NOISE:  smp = SMP_W'($urandom);
                WAVE_RAILS:  smp = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                WAVE_QUIET:  smp = SMP_W'($urandom_range(0, 127) - 64);
                WAVE_SQUARE: smp = ((n / half_period) % 2 == 0) ? SMP_MAX : SMP_MIN;
                default:     smp = level;
            endcase
            first = (n == 0) ? marked : ($urandom_range(0, 199) == 0);
            send_sample(smp, first);
        end
        if (len > longest_run) longest_run = len;
    endtask

    // Drop valid and hold the sender until every result is out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int rand_sent;
        int sel;
        int len;
        int wait_cycles;
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.sample_in       <= SMP_ZERO;
        in_ch.start_of_signal <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream taken as started at reset: no start mark yet
        send_sample(SMP_MAX, 1'b0);
        send_sample(SMP_MIN, 1'b0);
        send_sample(SMP_ZERO, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b0);
        // mark mid-phase: history and phase clear, this sample produces
        send_sample(16'shAAAA, 1'b1);
        send_sample(SMP_MAX, 1'b0);
        // back-to-back marks: each one produces
        send_sample(SMP_MAX, 1'b1);
        send_sample(SMP_MIN, 1'b1);
        send_sample(SMP_ZERO, 1'b1);
        for (int i = 0; i < 9; i++) send_sample((i % 2 == 0) ? SMP_MIN : SMP_MAX, 1'b0);

        // hold the sender until every result is out
        wait_drained();

        // long receiver hold-off while a short signal keeps arriving: input must stall
        rx_hold_req = 1'b1;
        send_signal(48, WAVE_NOISE, 1'b1);

        // one long square-wave signal: deep history, clips on the edges
        tx_idle_pct  = 10;
        rx_stall_pct = 10;
        send_signal(LONG_ITEMS, WAVE_SQUARE, 1'b1);

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (rand_sent >= RAND_ITEMS - CALM_ITEMS) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                sel          = $urandom_range(0, 2);
                tx_idle_pct  = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
                sel          = $urandom_range(0, 2);
                rx_stall_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)      len = $urandom_range(1, 48);
            else if (sel < 96) len = $urandom_range(49, 200);
            else               len = $urandom_range(201, 480);
            if (len > RAND_ITEMS - rand_sent) len = RAND_ITEMS - rand_sent;
            send_signal(len, t_wave'($urandom_range(0, 4)), $urandom_range(0, 9) != 0);
            rand_sent += len;
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        // a trailing sample can still be in the accumulator
        repeat (NTAPS + 8) @(posedge clk);

        $display("Covered %0d samples over %0d start marks, longest signal %0d samples,",
                 samples_sent, marks_sent, longest_run);
        $display("with %0d filtered results checked and %0d of them clipped at full scale.",
                 checked, saturated);
        if (fail_count == 0 && pending == 0) begin
            $display("sinc_lowpass_decimator regression: pass");
        end else begin
            $display("sinc_lowpass_decimator regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
design/sld_pkg.sv
design/sld_in_if.sv
design/sld_out_if.sv
design/sld_ctrl.sv
design/sld_datapath.sv
design/sinc_lowpass_decimator.sv
test/sld_checker.sv
test/tb.sv
